// ===== sv/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// Compensate block address package
// Shared constants, register indexes and the control interface between the
// sequencer and the datapath of the reference address generator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Default values of the structural parameters.
  localparam int DEF_BLOCK_SIZE   = 16;
  localparam int DEF_PAD          = 16;
  localparam int DEF_VECTOR_SHIFT = 0;

  // Field widths.
  localparam int VEC_W   = 16;
  localparam int SAD_W   = 20;
  localparam int CNT_W   = 10;
  localparam int TS_W    = 9;
  localparam int PEL_W   = 2;
  localparam int PITCH_W = 16;
  localparam int PLANE_W = 24;
  localparam int SLOT_W  = 5;
  localparam int ADDR_W  = 32;
  localparam int SEL_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAD_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEL_MODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_SUPER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_PITCH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_CUT     = 3'd7;

  // Reset values of the registers.
  localparam logic [CNT_W-1:0]   RST_BLOCKS_X    = 10'd3;
  localparam logic [CNT_W-1:0]   RST_BLOCKS_Y    = 10'd3;
  localparam logic [SAD_W-1:0]   RST_SAD_THRESH  = 20'd0;
  localparam logic [TS_W-1:0]    RST_TIME_SCALE  = 9'd256;
  localparam logic [PEL_W-1:0]   RST_PEL_MODE    = 2'd0;
  localparam logic [PITCH_W-1:0] RST_PITCH_SUPER = 16'd1;
  localparam logic [PLANE_W-1:0] RST_PLANE_PITCH = 24'd0;

  // Pel mode codes.
  localparam logic [PEL_W-1:0] PEL_FULL = 2'd0;
  localparam logic [PEL_W-1:0] PEL_HALF = 2'd1;

  // Edge class codes.
  localparam logic [1:0] CLS_FIRST = 2'd0;
  localparam logic [1:0] CLS_INNER = 2'd1;
  localparam logic [1:0] CLS_LAST  = 2'd2;

  // Select codes.
  localparam logic [SEL_W-1:0] SEL_ZERO   = 2'b00;
  localparam logic [SEL_W-1:0] SEL_VECTOR = 2'b01;
  localparam logic [SEL_W-1:0] SEL_CUT    = 2'b11;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic split;
    logic prod;
    logic sum;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

// ===== sv/cba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Compensate block address sequencer
// Steps one block through the capture, multiply, split, product and sum
// phases of the datapath, and takes the next word as the sum is stored.
// ----------------------------------------------------------------------------
module cba_ctrl
  import cba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SPLIT = 3'd2;
  localparam logic [2:0] ST_PROD  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       sum_done;

  // The result leaves the sum phase once the output register can take it.
  // No word is taken while reset is held.
  assign sum_done = (state == ST_SUM) && !status.out_stall;
  assign in_ready = !rst && ((state == ST_IDLE) || sum_done);

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.mul     = (state == ST_MUL);
    cmd.split   = (state == ST_SPLIT);
    cmd.prod    = (state == ST_PROD);
    cmd.sum     = sum_done;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SPLIT;
      ST_SPLIT: state_next = ST_PROD;
      ST_PROD:  state_next = ST_SUM;
      ST_SUM: begin
        if (sum_done) state_next = in_valid ? ST_MUL : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/cba_datapath.sv =====
// ----------------------------------------------------------------------------
// Compensate block address datapath
// Holds the configuration registers and block counters, scales and splits
// the motion vector, forms the reference address and keeps the result word.
// ----------------------------------------------------------------------------
module cba_datapath
  import cba_pkg::*;
#(
  parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
  parameter int PAD          = DEF_PAD,
  parameter int VECTOR_SHIFT = DEF_VECTOR_SHIFT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic [SAD_W-1:0]        block_sad,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SLOT_W-1:0]       window_slot,
  output logic [ADDR_W-1:0]       ref_address,
  output logic [SEL_W-1:0]        ref_select,
  output logic                    last_block
);

  localparam int STEP   = BLOCK_SIZE / 2;
  localparam int PROD_W = VEC_W + TS_W + 1;
  localparam int SCL_W  = PROD_W - 8;

  // Configuration registers.
  logic [CNT_W-1:0]   blocks_x;
  logic [CNT_W-1:0]   blocks_y;
  logic [SAD_W-1:0]   sad_threshold;
  logic [TS_W-1:0]    time_scale;
  logic [PEL_W-1:0]   pel_mode;
  logic [PITCH_W-1:0] pitch_super;
  logic [PLANE_W-1:0] plane_pitch;
  logic               scene_cut;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_x      <= RST_BLOCKS_X;
      blocks_y      <= RST_BLOCKS_Y;
      sad_threshold <= RST_SAD_THRESH;
      time_scale    <= RST_TIME_SCALE;
      pel_mode      <= RST_PEL_MODE;
      pitch_super   <= RST_PITCH_SUPER;
      plane_pitch   <= RST_PLANE_PITCH;
      scene_cut     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCKS_X:      blocks_x      <= cfg_data[CNT_W-1:0];
        REG_BLOCKS_Y:      blocks_y      <= cfg_data[CNT_W-1:0];
        REG_SAD_THRESHOLD: sad_threshold <= cfg_data[SAD_W-1:0];
        REG_TIME_SCALE:    time_scale    <= cfg_data[TS_W-1:0];
        REG_PEL_MODE:      pel_mode      <= cfg_data[PEL_W-1:0];
        REG_PITCH_SUPER:   pitch_super   <= cfg_data[PITCH_W-1:0];
        REG_PLANE_PITCH:   plane_pitch   <= cfg_data[PLANE_W-1:0];
        REG_SCENE_CUT:     scene_cut     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Edge classes and frame position of the block at the counters.
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_max;
  logic [CNT_W-1:0] row_max;
  logic             col_last;
  logic             row_last;
  logic [1:0]       col_cls;
  logic [1:0]       row_cls;
  logic [3:0]       slot_calc;

  always_comb begin
    col_max  = (blocks_x == '0) ? '0 : blocks_x - 1'b1;
    row_max  = (blocks_y == '0) ? '0 : blocks_y - 1'b1;
    col_last = column_count >= col_max;
    row_last = row_count >= row_max;
    if (column_count == '0) col_cls = CLS_FIRST;
    else if (col_last)      col_cls = CLS_LAST;
    else                    col_cls = CLS_INNER;
    if (row_count == '0)    row_cls = CLS_FIRST;
    else if (row_last)      row_cls = CLS_LAST;
    else                    row_cls = CLS_INNER;
    slot_calc = 4'({row_cls, 1'b0}) + 4'(row_cls) + 4'(col_cls);
  end

  // Block counters advance on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.capture) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Capture: an unused vector is replaced by zero, so it adds no offset.
  logic signed [VEC_W-1:0] vx_q;
  logic signed [VEC_W-1:0] vy_q;
  logic [CNT_W-1:0]        col_q;
  logic [CNT_W-1:0]        row_q;
  logic [3:0]              slot_q;
  logic                    last_q;
  logic                    cut_q;
  logic                    use_q;
  logic                    use_vec;

  assign use_vec = block_sad < sad_threshold;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vx_q   <= use_vec ? vec_x : '0;
      vy_q   <= use_vec ? vec_y : '0;
      col_q  <= column_count;
      row_q  <= row_count;
      slot_q <= slot_calc;
      last_q <= col_last && row_last;
      cut_q  <= scene_cut;
      use_q  <= use_vec;
    end
  end

  // Multiply phase: time scaling of both components and the row base.
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        row_term;

  assign row_term = ADDR_W'(PAD) + ADDR_W'(row_q) * ADDR_W'(STEP);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      px       <= PROD_W'(vx_q * $signed({1'b0, time_scale}));
      py       <= PROD_W'(vy_q * $signed({1'b0, time_scale}));
      row_base <= ADDR_W'(row_term * ADDR_W'(pitch_super));
    end
  end

  // Split phase: divide by 256 toward zero, shift, then full and subpel parts.
  logic signed [SCL_W-1:0] mx;
  logic signed [SCL_W-1:0] my;
  logic [1:0]              sh;
  logic [1:0]              sx;
  logic [1:0]              sy;
  logic [3:0]              plane_calc;
  logic signed [SCL_W-1:0] fx;
  logic signed [SCL_W-1:0] fy;
  logic [3:0]              plane;
  logic [ADDR_W-1:0]       base;

  always_comb begin
    mx = SCL_W'((px + (px[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8) >>> VECTOR_SHIFT;
    my = SCL_W'((py + (py[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8) >>> VECTOR_SHIFT;
    case (pel_mode)
      PEL_FULL: sh = 2'd0;
      PEL_HALF: sh = 2'd1;
      default:  sh = 2'd2;
    endcase
    sx = mx[1:0] & ~(2'b11 << sh);
    sy = my[1:0] & ~(2'b11 << sh);
    plane_calc = 4'(sx) + (4'(sy) << sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      fx    <= mx >>> sh;
      fy    <= my >>> sh;
      plane <= plane_calc;
      base  <= ADDR_W'(PAD) + ADDR_W'(col_q) * ADDR_W'(STEP) + row_base;
    end
  end

  // Product phase: vertical offset, subpel plane offset and the base plus the full horizontal part.
  logic [ADDR_W-1:0] fy_off;
  logic [ADDR_W-1:0] plane_off;
  logic [ADDR_W-1:0] base_fx;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      fy_off    <= ADDR_W'(fy * $signed({1'b0, pitch_super}));
      plane_off <= ADDR_W'(plane * plane_pitch);
      base_fx   <= base + ADDR_W'(fx);
    end
  end

  // Result word register.
  assign status.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sum) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      last_block <= last_q;
      if (cut_q) begin
        window_slot <= '1;
        ref_address <= '1;
        ref_select  <= SEL_CUT;
      end else begin
        window_slot <= SLOT_W'(slot_q);
        ref_address <= base_fx + fy_off + plane_off;
        ref_select  <= use_q ? SEL_VECTOR : SEL_ZERO;
      end
    end
  end

endmodule

// ===== sv/compensate_block_address_top.sv =====
// Path: a captured word passes the multiply, split, product and sum phases into
// the output register. Flow: the next block enters as the last sum is stored, as the
// sequencer's four phases share one capture register set; a stalled output holds
// the sum phase. Reset: synchronous rst returns the registers to their defaults
// and clears the column and row counters and the output valid flag.
// ----------------------------------------------------------------------------
// Compensate block address top level
// Streams one motion vector per block in raster order and gives the window
// slot, reference address and select code of each block.
// ----------------------------------------------------------------------------
module compensate_block_address_top
  import cba_pkg::*;
#(
  parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
  parameter int PAD          = DEF_PAD,
  parameter int VECTOR_SHIFT = DEF_VECTOR_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vec_x [15:0], vec_y [31:16], block_sad [51:32], zero [55:52]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // window_slot [4:0], ref_address [36:5], zero [39:37]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // ref_select [1:0]
  output logic [SEL_W-1:0]      m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t              cmd;
  status_t           status;
  logic [SLOT_W-1:0] window_slot;
  logic [ADDR_W-1:0] ref_address;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cba_datapath #(
    .BLOCK_SIZE   (BLOCK_SIZE),
    .PAD          (PAD),
    .VECTOR_SHIFT (VECTOR_SHIFT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .vec_x       (s_axis_tdata[15:0]),
    .vec_y       (s_axis_tdata[31:16]),
    .block_sad   (s_axis_tdata[51:32]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .window_slot (window_slot),
    .ref_address (ref_address),
    .ref_select  (m_axis_tuser),
    .last_block  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, ref_address, window_slot};

endmodule

// ===== tb/block_address_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block address checker
// Watches the configuration port and both stream channels of the reference
// address generator. It keeps its own copy of the registers and the block
// counters, works out the expected word for every accepted motion vector, and
// compares each result word, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module block_address_checker
  import cba_pkg::*;
#(
  parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
  parameter int PAD          = DEF_PAD,
  parameter int VECTOR_SHIFT = DEF_VECTOR_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // vec_x [15:0], vec_y [31:16], block_sad [51:32], zero [55:52]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // window_slot [4:0], ref_address [36:5], zero [39:37]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // ref_select [1:0]
  input  logic [SEL_W-1:0]      m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fail_count,
  output int                    pending,
  output int                    checked_count
);

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [SLOT_W-1:0] window_slot;
    logic [ADDR_W-1:0] ref_address;
    logic [SEL_W-1:0]  ref_select;
    logic              last_block;
  } block_result_t;

  // Register copy and block position.
  logic [CNT_W-1:0]   blocks_x, blocks_y;
  logic [SAD_W-1:0]   sad_threshold;
  logic [TS_W-1:0]    time_scale;
  logic [PEL_W-1:0]   pel_mode;
  logic [PITCH_W-1:0] pitch_super;
  logic [PLANE_W-1:0] plane_pitch;
  logic               scene_cut;
  logic [CNT_W-1:0]   col_count, row_count;

  // Expected words in arrival order, kept in a ring.
  block_result_t exp_fifo [EXP_DEPTH];
  int exp_head, exp_tail, exp_count;

  // Class of a position along one axis: first, inner or last. A count of zero
  // acts as one, and position zero is always first.
  function automatic logic [1:0] edge_class(input logic [CNT_W-1:0] pos,
                                            input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] n;
    n = (count == '0) ? CNT_W'(1) : count;
    if (pos == '0) return CLS_FIRST;
    if (pos >= n - CNT_W'(1)) return CLS_LAST;
    return CLS_INNER;
  endfunction

  // Expected word of the block at the current counter position.
  function automatic block_result_t compute_reference(input logic signed [VEC_W-1:0] vx,
                                                      input logic signed [VEC_W-1:0] vy,
                                                      input logic [SAD_W-1:0] sad);
    block_result_t r;
    logic [CNT_W-1:0] bx, by;
    logic [1:0] row_cls, col_cls;
    logic [ADDR_W-1:0] base, offset, sub_mask, sub_x, sub_y, full_x, full_y, plane;
    int mx, my;
    int shift;
    bx = (blocks_x == '0) ? CNT_W'(1) : blocks_x;
    by = (blocks_y == '0) ? CNT_W'(1) : blocks_y;
    r.last_block = (col_count >= bx - CNT_W'(1)) && (row_count >= by - CNT_W'(1));
    if (scene_cut) begin
      r.window_slot = '1;
      r.ref_address = '1;
      r.ref_select  = SEL_CUT;
    end else begin
      base = (32'(PAD) + 32'(col_count) * 32'(BLOCK_SIZE / 2)) +
             (32'(PAD) + 32'(row_count) * 32'(BLOCK_SIZE / 2)) * 32'(pitch_super);
      row_cls = edge_class(row_count, blocks_y);
      col_cls = edge_class(col_count, blocks_x);
      r.window_slot = SLOT_W'(row_cls * 3 + col_cls);
      if (sad < sad_threshold) begin
        // Scale with truncation toward zero, then shift with floor.
        mx = ((int'(vx) * int'(time_scale)) / 256) >>> VECTOR_SHIFT;
        my = ((int'(vy) * int'(time_scale)) / 256) >>> VECTOR_SHIFT;
        shift = (pel_mode == PEL_FULL) ? 0 : ((pel_mode == PEL_HALF) ? 1 : 2);
        sub_mask = (32'd1 << shift) - 32'd1;
        sub_x  = mx & sub_mask;
        sub_y  = my & sub_mask;
        full_x = mx >>> shift;
        full_y = my >>> shift;
        plane  = sub_x + (sub_y << shift);
        offset = full_x + full_y * 32'(pitch_super) + plane * 32'(plane_pitch);
        r.ref_address = base + offset;
        r.ref_select  = SEL_VECTOR;
      end else begin
        r.ref_address = base;
        r.ref_select  = SEL_ZERO;
      end
    end
    return r;
  endfunction

  // Track registers, check result words, and predict accepted vectors.
  always @(posedge clk) begin
    block_result_t exp_word, got_word, new_word;
    logic [CNT_W-1:0] bx, by;
    if (rst) begin
      blocks_x      = RST_BLOCKS_X;
      blocks_y      = RST_BLOCKS_Y;
      sad_threshold = RST_SAD_THRESH;
      time_scale    = RST_TIME_SCALE;
      pel_mode      = RST_PEL_MODE;
      pitch_super   = RST_PITCH_SUPER;
      plane_pitch   = RST_PLANE_PITCH;
      scene_cut     = 1'b0;
      col_count     = '0;
      row_count     = '0;
      exp_head      = 0;
      exp_tail      = 0;
      exp_count     = 0;
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCKS_X:      blocks_x      = cfg_data[CNT_W-1:0];
          REG_BLOCKS_Y:      blocks_y      = cfg_data[CNT_W-1:0];
          REG_SAD_THRESHOLD: sad_threshold = cfg_data[SAD_W-1:0];
          REG_TIME_SCALE:    time_scale    = cfg_data[TS_W-1:0];
          REG_PEL_MODE:      pel_mode      = cfg_data[PEL_W-1:0];
          REG_PITCH_SUPER:   pitch_super   = cfg_data[PITCH_W-1:0];
          REG_PLANE_PITCH:   plane_pitch   = cfg_data[PLANE_W-1:0];
          REG_SCENE_CUT:     scene_cut     = cfg_data[0];
          default: ;
        endcase
      end

      // Compare a result word with the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.window_slot = m_axis_tdata[4:0];
        got_word.ref_address = m_axis_tdata[36:5];
        got_word.ref_select  = m_axis_tuser;
        got_word.last_block  = m_axis_tlast;
        if (exp_count == 0) begin
          $error("result word 0x%h arrived with no block pending", m_axis_tdata);
          fail_count++;
        end else begin
          exp_word = exp_fifo[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          checked_count++;
          if (got_word.window_slot !== exp_word.window_slot) begin
            $error("window_slot: expected 0x%h, got 0x%h",
                   exp_word.window_slot, got_word.window_slot);
            fail_count++;
          end
          if (got_word.ref_address !== exp_word.ref_address) begin
            $error("ref_address: expected 0x%h, got 0x%h",
                   exp_word.ref_address, got_word.ref_address);
            fail_count++;
          end
          if (got_word.ref_select !== exp_word.ref_select) begin
            $error("ref_select: expected 0x%h, got 0x%h",
                   exp_word.ref_select, got_word.ref_select);
            fail_count++;
          end
          if (got_word.last_block !== exp_word.last_block) begin
            $error("last_block: expected %0b, got %0b",
                   exp_word.last_block, got_word.last_block);
            fail_count++;
          end
        end
      end

      // Predict the accepted vector, then advance the raster position.
      if (s_axis_tvalid && s_axis_tready) begin
        new_word = compute_reference(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                     s_axis_tdata[51:32]);
        if (exp_count == EXP_DEPTH) begin
          $error("more than %0d blocks in flight", EXP_DEPTH);
          fail_count++;
        end else begin
          exp_fifo[exp_tail] = new_word;
          exp_tail = (exp_tail + 1) % EXP_DEPTH;
          exp_count++;
        end
        bx = (blocks_x == '0) ? CNT_W'(1) : blocks_x;
        by = (blocks_y == '0) ? CNT_W'(1) : blocks_y;
        if (col_count >= bx - CNT_W'(1)) begin
          col_count = '0;
          row_count = (row_count >= by - CNT_W'(1)) ? '0 : row_count + CNT_W'(1);
        end else begin
          col_count = col_count + CNT_W'(1);
        end
      end
    end
    pending = exp_count;
  end

endmodule

// ===== tb/compensate_block_address_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensate block address testbench
// Drives motion vectors into the reference address generator under several
// register settings and idling patterns: first a directed frame set covering
// field extremes, all pel modes, tiny frames, scene cut and counters beyond
// the frame size, then random segments. The checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module compensate_block_address_top_test;
  import cba_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCKS_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // vec_x [15:0], vec_y [31:16], block_sad [51:32], zero [55:52]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // window_slot [4:0], ref_address [36:5], zero [39:37]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // ref_select [1:0]
  logic [SEL_W-1:0]      m_axis_tuser;
  logic                  m_axis_tlast;

  int fail_count, pending, checked_count;
  int gap_pct = 0;
  int stall_pct = 0;
  int blocks_sent = 0;
  int settings_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  compensate_block_address_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  block_address_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
  );

  // Result side: stall at random while a stall rate is set.
  always @(negedge clk) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure(input int bx, input int by, input int thr, input int ts,
                           input int pel, input int pitch, input int plane,
                           input int cut);
    drain_results();
    write_reg(REG_BLOCKS_X, CFG_DATA_W'(bx));
    write_reg(REG_BLOCKS_Y, CFG_DATA_W'(by));
    write_reg(REG_SAD_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_TIME_SCALE, CFG_DATA_W'(ts));
    write_reg(REG_PEL_MODE, CFG_DATA_W'(pel));
    write_reg(REG_PITCH_SUPER, CFG_DATA_W'(pitch));
    write_reg(REG_PLANE_PITCH, CFG_DATA_W'(plane));
    write_reg(REG_SCENE_CUT, CFG_DATA_W'(cut));
    settings_count++;
  endtask

  // Offer one vector word, with random idle cycles ahead of it.
  task automatic send_block(input logic [VEC_W-1:0] vx, input logic [VEC_W-1:0] vy,
                            input logic [SAD_W-1:0] sad);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sad, vy, vx};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    blocks_sent++;
  endtask

  function automatic int pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 1023;
      default: return $urandom_range(3, 6);
    endcase
  endfunction

  initial begin
    int thr, seg_len, random_blocks, phase;
    logic [VEC_W-1:0] vx, vy;
    logic [SAD_W-1:0] sad;
    random_blocks = 0;
    phase = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Quarter pel over one full 3x3 frame with field extremes.
    configure(3, 3, 20'hFFFFF, 256, 2, 1000, 5000, 0);
    send_block(16'h7FFF, 16'h8000, 20'h00000);
    send_block(16'h8000, 16'h7FFF, 20'h00000);
    send_block(16'hFFFF, 16'hFFFF, 20'h00001);
    send_block(16'h0001, 16'h0001, 20'h00002);
    send_block(16'h0000, 16'h0000, 20'hFFFFE);
    send_block(16'h0005, 16'hFFF9, 20'hFFFFF);
    send_block(16'hFFFB, 16'h0007, 20'h00000);
    send_block(16'h7FFF, 16'h7FFF, 20'h12345);
    send_block(16'h8000, 16'h8000, 20'h00000);

    // Undefined pel mode, large time scale and a frame with a row count of zero.
    configure(1, 0, 20'hFFFFF, 511, 3, 65535, 24'hFFFFFF, 0);
    send_block(16'hFFFD, 16'h0003, 20'h00000);
    send_block(16'h7FFF, 16'h8000, 20'h00000);
    send_block(16'h0006, 16'hFFFA, 20'h00010);
    send_block(16'h1234, 16'hEDCB, 20'h00000);

    // Half pel with zero time scale; leave the counters mid frame.
    configure(2, 2, 20'h00100, 0, 1, 640, 100, 0);
    send_block(16'h7FFF, 16'h7FFF, 20'h000FF);
    send_block(16'h8000, 16'h0001, 20'h00100);
    send_block(16'hFFFF, 16'h8000, 20'h00000);

    // Scene cut with the frame shrunk below the counters.
    configure(1, 1, 20'hFFFFF, 256, 2, 1000, 5000, 1);
    send_block(16'h0010, 16'h0020, 20'h00000);
    send_block(16'hFFF0, 16'hFFE0, 20'hFFFFF);
    send_block(16'h0000, 16'h0000, 20'h00000);
    send_block(16'h7FFF, 16'h8000, 20'h00000);

    // Full pel, zero pitch, largest frame, threshold in the middle.
    configure(1023, 1023, 20'h80000, 128, 0, 0, 24'hFFFFFF, 0);
    send_block(16'h7FFF, 16'h8000, 20'h7FFFF);
    send_block(16'h8000, 16'h7FFF, 20'h80000);
    send_block(16'hFFFF, 16'h0001, 20'h00000);
    send_block(16'h0003, 16'hFFFD, 20'hFFFFF);
    send_block(16'hAAAA, 16'h5555, 20'h55555);

    // Random segments, each with its own setting and idling pattern.
    while (random_blocks < 500) begin
      drain_results();
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 88; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 88; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      phase++;
      case ($urandom_range(4))
        0: thr = 0;
        1: thr = 20'hFFFFF;
        default: thr = $urandom_range(1, 20'hFFFFF);
      endcase
      configure(pick_count(), pick_count(), thr,
                ($urandom_range(3) == 0) ? 256 : $urandom_range(0, 511),
                $urandom_range(3),
                ($urandom_range(7) == 0) ? 0 : $urandom_range(0, 65535),
                $urandom_range(0, 24'hFFFFFF),
                ($urandom_range(7) == 0) ? 1 : 0);
      seg_len = $urandom_range(15, 45);
      repeat (seg_len) begin
        if ($urandom_range(1) == 0) begin
          vx = VEC_W'($urandom);
          vy = VEC_W'($urandom);
        end else begin
          vx = VEC_W'($urandom_range(0, 31) - 16);
          vy = VEC_W'($urandom_range(0, 31) - 16);
        end
        // Unless the threshold is zero, most vectors fall below it so the offset path is busy.
        if (thr == 0 || $urandom_range(3) == 0) sad = SAD_W'($urandom);
        else sad = SAD_W'($urandom_range(0, thr - 1));
        send_block(vx, vy, sad);
        random_blocks++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("Checked %0d result words from %0d blocks over %0d register settings,",
             checked_count, blocks_sent, settings_count);
    $display("with all pel modes, scene cuts, tiny and shrunk frames and four idling patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cba_pkg.sv
sv/cba_ctrl.sv
sv/cba_datapath.sv
sv/compensate_block_address_top.sv
tb/block_address_checker.sv
tb/compensate_block_address_top_test.sv
